>>> rtl/core/jee_pkg.sv
// jee_pkg: widths, command codes, symbol constants and the category
// function shared by the jpeg entropy encoder; depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package jee_pkg;
    localparam int unsigned COEFF_W = 12;
    localparam int unsigned DIFF_W  = COEFF_W + 1;
    localparam int unsigned CODE_W  = 16;
    localparam int unsigned LEN_W   = 5;
    localparam int unsigned ADDR_W  = 10;
    localparam int unsigned ENTRY_W = LEN_W + CODE_W;
    localparam int unsigned DEPTH   = 1 << ADDR_W;
    localparam int unsigned TDATA_W = 56;
    localparam int unsigned PUT_W   = CODE_W + COEFF_W;
    localparam int unsigned BUF_W   = 48;
    localparam int unsigned CNT_W   = 6;
    localparam int unsigned SIZE_W  = 4;
    localparam int unsigned RUN_W   = 6;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_COEFF = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;
    localparam logic [1:0] COMP_NONE = 2'd3;

    localparam logic [7:0] SYM_ZRL   = 8'hF0;
    localparam logic [7:0] SYM_EOB   = 8'h00;
    localparam logic [7:0] BYTE_FF   = 8'hFF;
    localparam logic [7:0] BYTE_STUF = 8'h00;

    localparam logic [5:0]     LAST_POS = 6'd63;
    localparam logic [RUN_W-1:0] RUN_MAX = 6'd63;
    localparam logic [LEN_W-1:0] MAX_LEN = 5'd16;

    // number of significant bits of a magnitude
    function automatic logic [SIZE_W-1:0] category(input logic [DIFF_W-1:0] mag);
        logic [SIZE_W-1:0] c;
        c = '0;
        for (int i = 0; i < DIFF_W; i++) begin
            if (mag[i]) begin
                c = SIZE_W'(i + 1);
            end
        end
        return c;
    endfunction
endpackage
`default_nettype wire

>>> rtl/core/jpeg_entropy_encoder.sv
// jpeg_entropy_encoder: baseline huffman entropy coder with code table memory,
// dc predictors and msb-first byte packer with 0xff stuffing
// depends on jee_pkg
//
// usage:
//   slave stream carries commands: tuser = command (load / coefficient / flush).
//   a load writes one entry of the code table memory in its accept cycle.
//   coefficients arrive in zigzag order; zero coefficients that emit nothing
//   and ignored items are taken one per cycle while the slot can take them
//   and never occupy the coder. items that emit codes enter a one-item
//   slot; the table entry is read from a synchronous memory addressed in
//   the accept cycle, ready the next cycle. puts go in order (zrl codes
//   first, then the main code with its magnitude bits); the slot takes the
//   next item in the cycle of its final put, giving one item a cycle while
//   output keeps up and no zrl code is due. a put waits until the whole
//   bytes before it have gone out, except that the last whole byte of a
//   zrl put stays in the packer until the item's next put, so tlast lands
//   on the item's true final byte. bytes leave one per cycle through an
//   output register; an item's first byte passes the slot, the packer and
//   the output register. a receiver stall holds the output register and the
//   packer; the slot and then the slave side back up behind it.
//   reset (sync, active low) clears predictors, zero run, packer and valids;
//   the code table is not cleared and must be loaded before use.
//   flush pads the last partial byte with zeros, sends it with tlast and
//   clears the predictors and the zero run.
`timescale 1ns / 1ps
`default_nettype none
module jpeg_entropy_encoder (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_tvalid,
    output logic                              o_s_tready,
    // table_select[1:0], symbol[9:2], code_bits[25:10], code_length[30:26],
    // coefficient[42:31], position[48:43], component[50:49], zero fill above
    input  wire logic [jee_pkg::TDATA_W-1:0]  i_s_tdata,
    // command[1:0]
    input  wire logic [1:0]                   i_s_tuser,
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    // out_byte[7:0]
    output logic [7:0]                        o_m_tdata,
    output logic                              o_m_tlast
);
    // input fields
    logic [1:0]                      w_tsel;
    logic [7:0]                      w_symbol;
    logic [jee_pkg::CODE_W-1:0]      w_code_in;
    logic [jee_pkg::LEN_W-1:0]       w_len_in;
    logic [jee_pkg::COEFF_W-1:0]     w_coeff;
    logic [5:0]                      w_pos;
    logic [1:0]                      w_comp;

    assign w_tsel    = i_s_tdata[1:0];
    assign w_symbol  = i_s_tdata[9:2];
    assign w_code_in = i_s_tdata[25:10];
    assign w_len_in  = i_s_tdata[30:26];
    assign w_coeff   = i_s_tdata[42:31];
    assign w_pos     = i_s_tdata[48:43];
    assign w_comp    = i_s_tdata[50:49];

    // code table memory: length in the top bits, code right aligned
    logic [jee_pkg::ENTRY_W-1:0] r_mem [jee_pkg::DEPTH];
    logic [jee_pkg::ENTRY_W-1:0] r_rdata;

    // dc predictors and zero run
    logic [jee_pkg::COEFF_W-1:0] r_pred [3];
    logic [jee_pkg::RUN_W-1:0]   r_run;

    // coding slot
    logic                        r_v, n_v;
    logic                        r_flush, n_flush;
    logic [1:0]                  r_nzrl, n_nzrl;
    logic [1:0]                  r_tab, n_tab;
    logic [7:0]                  r_sym, n_sym;
    logic [jee_pkg::SIZE_W-1:0]  r_vsize, n_vsize;
    logic [jee_pkg::COEFF_W-1:0] r_vbits, n_vbits;

    // packer
    logic [jee_pkg::BUF_W-1:0]   r_buf;
    logic [jee_pkg::CNT_W-1:0]   r_cnt;
    logic                        r_stuff;
    logic                        r_tail;

    // output register
    logic                        r_ov;
    logic [7:0]                  r_obyte;
    logic                        r_olast;

    // accept side decode
    logic                        w_acc;
    logic                        w_coef_ok;
    logic                        w_chroma;
    logic                        w_dc;
    logic                        w_zero;
    logic                        w_eob;
    logic                        w_work;
    logic [jee_pkg::COEFF_W-1:0] w_pred;
    logic [jee_pkg::DIFF_W-1:0]  w_val;
    logic [jee_pkg::DIFF_W-1:0]  w_mag;
    logic                        w_neg;
    logic [jee_pkg::SIZE_W-1:0]  w_size;
    logic [jee_pkg::DIFF_W-1:0]  w_vmask;
    logic [jee_pkg::DIFF_W-1:0]  w_vraw;
    logic [jee_pkg::LEN_W-1:0]   w_ld_len;
    logic [jee_pkg::CODE_W-1:0]  w_ld_mask;
    logic [jee_pkg::ADDR_W-1:0]  w_raddr;

    // put / drain
    logic                        w_put;
    logic                        w_fin;
    logic                        w_out_free;
    logic                        w_drain;
    logic [jee_pkg::LEN_W-1:0]   w_len;
    logic [jee_pkg::CODE_W-1:0]  w_code;
    logic [jee_pkg::SIZE_W-1:0]  w_vs;
    logic [jee_pkg::COEFF_W-1:0] w_vb;
    logic [jee_pkg::PUT_W-1:0]   w_cv;
    logic [jee_pkg::CNT_W-1:0]   w_plen;
    logic [jee_pkg::BUF_W-1:0]   w_placed;
    logic [7:0]                  w_top;
    logic [jee_pkg::CNT_W-1:0]   w_cnt_after;

    assign w_acc     = i_s_tvalid && o_s_tready;
    assign w_coef_ok = (i_s_tuser == jee_pkg::CMD_COEFF) && (w_comp != jee_pkg::COMP_NONE);
    assign w_chroma  = (w_comp != 2'd0);
    assign w_dc      = (w_pos == 6'd0);
    assign w_zero    = (w_coeff == '0);
    assign w_eob     = w_zero && (w_pos == jee_pkg::LAST_POS);
    assign w_work    = (w_coef_ok && (w_dc || !w_zero || w_eob))
                    || (i_s_tuser == jee_pkg::CMD_FLUSH);

    always_comb begin
        case (w_comp)
            2'd1:    w_pred = r_pred[1];
            2'd2:    w_pred = r_pred[2];
            default: w_pred = r_pred[0];
        endcase
    end

    // difference for dc, the coefficient itself for ac
    assign w_val   = w_dc ? ({w_coeff[jee_pkg::COEFF_W-1], w_coeff}
                             - {w_pred[jee_pkg::COEFF_W-1], w_pred})
                          : {w_coeff[jee_pkg::COEFF_W-1], w_coeff};
    assign w_neg   = w_val[jee_pkg::DIFF_W-1];
    assign w_mag   = w_neg ? (~w_val + 1'b1) : w_val;
    assign w_size  = jee_pkg::category(w_mag);
    assign w_vmask = (jee_pkg::DIFF_W'(1) << w_size) - jee_pkg::DIFF_W'(1);
    // negative values send v-1 in the category width
    assign w_vraw  = (w_neg ? (w_val - jee_pkg::DIFF_W'(1)) : w_val) & w_vmask;

    // table load: length saturates, code masked to the length
    assign w_ld_len  = (w_len_in > jee_pkg::MAX_LEN) ? jee_pkg::MAX_LEN : w_len_in;
    assign w_ld_mask = (w_ld_len >= jee_pkg::MAX_LEN) ? '1
                     : jee_pkg::CODE_W'((17'd1 << w_ld_len) - 17'd1);

    // packer step: a later put of the same item may land behind a held byte
    assign w_put  = r_v && !r_stuff
                 && ((r_cnt < jee_pkg::CNT_W'(8))
                     || (!r_tail && (r_cnt < jee_pkg::CNT_W'(16))));
    assign w_fin  = w_put && (r_flush || (r_nzrl == 2'd0));
    assign o_s_tready = !r_v || w_fin;

    assign w_len  = r_rdata[jee_pkg::ENTRY_W-1:jee_pkg::CODE_W];
    assign w_code = r_rdata[jee_pkg::CODE_W-1:0];
    assign w_vs   = (r_nzrl != 2'd0) ? '0 : r_vsize;
    assign w_vb   = (r_nzrl != 2'd0) ? '0 : r_vbits;
    assign w_cv   = (jee_pkg::PUT_W'(w_code) << w_vs) | jee_pkg::PUT_W'(w_vb);
    assign w_plen = jee_pkg::CNT_W'(w_len) + jee_pkg::CNT_W'(w_vs);
    // left justify the new bits, then place them behind the pending ones
    assign w_placed = ({w_cv, {(jee_pkg::BUF_W - jee_pkg::PUT_W){1'b0}}}
                       << (jee_pkg::CNT_W'(jee_pkg::PUT_W) - w_plen)) >> r_cnt;

    // the last whole byte of a zrl put waits for the item's next put
    assign w_out_free  = !r_ov || i_m_tready;
    assign w_cnt_after = r_cnt - jee_pkg::CNT_W'(8);
    assign w_drain     = w_out_free && (r_stuff || ((r_cnt >= jee_pkg::CNT_W'(8))
                         && (r_tail || (w_cnt_after >= jee_pkg::CNT_W'(8)))));
    assign w_top       = r_buf[jee_pkg::BUF_W-1 -: 8];

    // next slot contents
    always_comb begin
        n_v     = r_v;
        n_flush = r_flush;
        n_nzrl  = r_nzrl;
        n_tab   = r_tab;
        n_sym   = r_sym;
        n_vsize = r_vsize;
        n_vbits = r_vbits;
        if (w_fin) begin
            n_v = 1'b0;
        end else if (w_put) begin
            n_nzrl = r_nzrl - 2'd1;
        end
        if (w_acc && w_work) begin
            n_v     = 1'b1;
            n_flush = (i_s_tuser == jee_pkg::CMD_FLUSH);
            n_nzrl  = 2'd0;
            n_tab   = {1'b1, w_chroma};
            n_sym   = jee_pkg::SYM_EOB;
            n_vsize = '0;
            n_vbits = '0;
            if (w_coef_ok) begin
                if (w_dc) begin
                    n_tab   = {1'b0, w_chroma};
                    n_sym   = {4'd0, w_size};
                    n_vsize = w_size;
                    n_vbits = w_vraw[jee_pkg::COEFF_W-1:0];
                end else if (!w_zero) begin
                    n_nzrl  = r_run[5:4];
                    n_sym   = {r_run[3:0], w_size};
                    n_vsize = w_size;
                    n_vbits = w_vraw[jee_pkg::COEFF_W-1:0];
                end
            end
        end
    end

    // zrl entry while zrl codes remain, else the item's own symbol
    assign w_raddr = {n_tab, (n_nzrl != 2'd0) ? jee_pkg::SYM_ZRL : n_sym};

    always_ff @(posedge i_clk) begin
        if (w_acc && (i_s_tuser == jee_pkg::CMD_LOAD)) begin
            r_mem[{w_tsel, w_symbol}] <= {w_ld_len, w_code_in & w_ld_mask};
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_flush <= n_flush;
        r_nzrl  <= n_nzrl;
        r_tab   <= n_tab;
        r_sym   <= n_sym;
        r_vsize <= n_vsize;
        r_vbits <= n_vbits;
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
    end

    // predictors and zero run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pred[0] <= '0;
            r_pred[1] <= '0;
            r_pred[2] <= '0;
            r_run     <= '0;
        end else if (w_acc) begin
            if (i_s_tuser == jee_pkg::CMD_FLUSH) begin
                r_pred[0] <= '0;
                r_pred[1] <= '0;
                r_pred[2] <= '0;
                r_run     <= '0;
            end else if (w_coef_ok) begin
                if (w_dc) begin
                    r_pred[w_comp] <= w_coeff;
                    r_run          <= '0;
                end else if (w_zero) begin
                    if (w_eob) begin
                        r_run <= '0;
                    end else if (r_run < jee_pkg::RUN_MAX) begin
                        r_run <= r_run + 1'b1;
                    end
                end else begin
                    r_run <= '0;
                end
            end
        end
    end

    // bit packer and byte drain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf   <= '0;
            r_cnt   <= '0;
            r_stuff <= 1'b0;
            r_tail  <= 1'b0;
        end else if (w_put) begin
            if (r_flush) begin
                // pad bits are already zero
                r_cnt  <= (r_cnt != '0) ? jee_pkg::CNT_W'(8) : '0;
                r_tail <= 1'b1;
            end else begin
                r_buf  <= r_buf | w_placed;
                r_cnt  <= r_cnt + w_plen;
                r_tail <= w_fin;
            end
        end else if (w_drain) begin
            if (r_stuff) begin
                r_stuff <= 1'b0;
            end else begin
                r_buf   <= r_buf << 8;
                r_cnt   <= w_cnt_after;
                r_stuff <= (w_top == jee_pkg::BYTE_FF);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_drain) begin
            if (r_stuff) begin
                r_obyte <= jee_pkg::BYTE_STUF;
                r_olast <= r_tail && (r_cnt < jee_pkg::CNT_W'(8));
            end else begin
                r_obyte <= w_top;
                r_olast <= r_tail && (w_cnt_after < jee_pkg::CNT_W'(8))
                        && (w_top != jee_pkg::BYTE_FF);
            end
        end
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_drain) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_obyte;
    assign o_m_tlast  = r_olast;
endmodule
`default_nettype wire

>>> dv/jpeg_entropy_encoder_tb.sv
// jpeg_entropy_encoder_tb: self-checking testbench for the jpeg entropy encoder
// a scoreboard class predicts the stuffed byte stream per transfer; depends on jee_pkg
`timescale 1ns / 1ps
module jpeg_entropy_encoder_tb;
    localparam logic [1:0] CMD_NONE   = 2'd3;   // reserved command, ignored
    localparam int         ITEM_GOAL  = 370;
    localparam int         CYCLE_CAP  = 200000;
    localparam int         HOLD_START = 150;    // receiver holds off from here
    localparam int         HOLD_LEN   = 200;
    localparam int         CALM_START = 450;    // no idling on either side
    localparam int         CALM_END   = 750;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_scan_byte;

    // predicts scan bytes from accepted commands and checks the output stream
    class jee_scoreboard;
        logic [jee_pkg::ENTRY_W-1:0] code_mem [jee_pkg::DEPTH];
        bit                          loaded   [jee_pkg::DEPTH];
        logic [jee_pkg::COEFF_W-1:0] dc_pred  [3];
        int                          zero_run;
        logic [7:0]                  acc_bits;
        int                          acc_cnt;
        t_scan_byte                  burst [$];
        t_scan_byte                  scan_q [$];
        int                          errors;

        function new();
            foreach (loaded[i]) loaded[i] = 0;
            foreach (dc_pred[i]) dc_pred[i] = '0;
            zero_run = 0;
            acc_bits = '0;
            acc_cnt  = 0;
            errors   = 0;
        endfunction

        function int size_of(int v);
            int m;
            int c;
            m = (v < 0) ? -v : v;
            c = 0;
            while (m != 0) begin
                c++;
                m = m >> 1;
            end
            return c;
        endfunction

        function int dc_diff(int comp, int coeff);
            return coeff - int'($signed(dc_pred[comp]));
        endfunction

        function void add_bits(int unsigned v, int n);
            t_scan_byte tb_byte;
            for (int i = n - 1; i >= 0; i--) begin
                acc_bits = {acc_bits[6:0], v[i]};
                acc_cnt++;
                if (acc_cnt == 8) begin
                    tb_byte.data = acc_bits;
                    tb_byte.last = 1'b0;
                    burst.push_back(tb_byte);
                    // byte stuffing after 0xff
                    if (acc_bits == jee_pkg::BYTE_FF) begin
                        tb_byte.data = jee_pkg::BYTE_STUF;
                        burst.push_back(tb_byte);
                    end
                    acc_bits = '0;
                    acc_cnt  = 0;
                end
            end
        endfunction

        function void add_code(int tsel, int sym);
            logic [jee_pkg::ENTRY_W-1:0] e;
            e = code_mem[tsel * 256 + sym];
            add_bits(32'(e[jee_pkg::CODE_W-1:0]),
                     int'(e[jee_pkg::ENTRY_W-1:jee_pkg::CODE_W]));
        endfunction

        function void add_mag(int v, int n);
            int unsigned b;
            if (n == 0) return;
            b = unsigned'((v < 0) ? v - 1 : v);
            b = b & ((32'd1 << n) - 32'd1);
            add_bits(b, n);
        endfunction

        // called for every accepted input transfer
        function void note_input(logic [1:0] cmd, logic [jee_pkg::TDATA_W-1:0] d);
            int tsel, sym, len, coeff, pos, comp, ch, n, diff;
            int unsigned code;
            t_scan_byte tb_byte;
            tsel  = int'(d[1:0]);
            sym   = int'(d[9:2]);
            code  = 32'(d[25:10]);
            len   = int'(d[30:26]);
            coeff = int'($signed(d[42:31]));
            pos   = int'(d[48:43]);
            comp  = int'(d[50:49]);
            if (cmd == jee_pkg::CMD_LOAD) begin
                if (len > int'(jee_pkg::MAX_LEN)) len = int'(jee_pkg::MAX_LEN);
                code = code & ((32'd1 << len) - 32'd1);
                code_mem[tsel * 256 + sym] = {5'(len), 16'(code)};
                loaded[tsel * 256 + sym]   = 1;
            end else if (cmd == jee_pkg::CMD_COEFF && comp != int'(jee_pkg::COMP_NONE)) begin
                ch = (comp != 0);
                if (pos == 0) begin
                    diff = dc_diff(comp, coeff);
                    n = size_of(diff);
                    add_code(ch, n);
                    add_mag(diff, n);
                    dc_pred[comp] = d[42:31];
                    zero_run = 0;
                end else if (coeff == 0) begin
                    if (zero_run < int'(jee_pkg::RUN_MAX)) zero_run++;
                    if (pos == int'(jee_pkg::LAST_POS)) begin
                        add_code(2 | ch, int'(jee_pkg::SYM_EOB));
                        zero_run = 0;
                    end
                end else begin
                    n = size_of(coeff);
                    while (zero_run >= 16) begin
                        add_code(2 | ch, int'(jee_pkg::SYM_ZRL));
                        zero_run -= 16;
                    end
                    add_code(2 | ch, (zero_run << 4) | (n & 15));
                    add_mag(coeff, n);
                    zero_run = 0;
                end
            end else if (cmd == jee_pkg::CMD_FLUSH) begin
                if (acc_cnt > 0) begin
                    tb_byte.data = 8'(acc_bits << (8 - acc_cnt));
                    tb_byte.last = 1'b0;
                    burst.push_back(tb_byte);
                end
                acc_bits = '0;
                acc_cnt  = 0;
                zero_run = 0;
                foreach (dc_pred[i]) dc_pred[i] = '0;
            end
            if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
            foreach (burst[i]) scan_q.push_back(burst[i]);
            burst.delete();
        endfunction

        // called for every accepted output transfer
        function void check_byte(logic [7:0] data, logic last);
            t_scan_byte want;
            if (scan_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected byte: expected none, got %02h last %0b",
                             data, last);
                return;
            end
            want = scan_q.pop_front();
            if (want.data !== data || want.last !== last) begin
                errors++;
                if (errors <= 10)
                    $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                             want.data, want.last, data, last);
            end
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_s_tvalid;
    logic                         o_s_tready;
    logic [jee_pkg::TDATA_W-1:0]  i_s_tdata;
    logic [1:0]                   i_s_tuser;
    logic                         o_m_tvalid;
    logic                         i_m_tready;
    logic [7:0]                   o_m_tdata;
    logic                         o_m_tlast;

    jee_scoreboard sb;
    int            cyc;
    int            items;

    jpeg_entropy_encoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle counter and watchdog
    initial cyc = 0;
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_CAP) begin
            $display("jpeg_entropy_encoder_tb: FAIL");
            $finish;
        end
    end

    function automatic bit calm();
        return cyc >= CALM_START && cyc < CALM_END;
    endfunction

    // receiver: random stalls, one long hold-off so the encoder backs up
    initial begin
        int held;
        held       = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (cyc >= HOLD_START && held < HOLD_LEN) begin
                i_m_tready = 1'b0;
                held++;
            end else begin
                i_m_tready = calm() || ($urandom_range(0, 99) >= 15);
            end
        end
    end

    // output monitor, samples at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_byte(o_m_tdata, o_m_tlast);
    end

    // one input transfer with random idle gaps before it
    task automatic send(logic [1:0] cmd, logic [jee_pkg::TDATA_W-1:0] d);
        while (!calm() && $urandom_range(0, 99) < 15) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = cmd;
        i_s_tdata  = d;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_input(cmd, d);
        items++;
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    // random fill for fields the command does not use
    function automatic logic [jee_pkg::TDATA_W-1:0] junk();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return {5'd0, r[50:0]};
    endfunction

    task automatic load_entry(int tsel, int sym, int code, int len);
        logic [jee_pkg::TDATA_W-1:0] d;
        d = junk();
        d[1:0]   = 2'(tsel);
        d[9:2]   = 8'(sym);
        d[25:10] = 16'(code);
        d[30:26] = 5'(len);
        send(jee_pkg::CMD_LOAD, d);
    endtask

    // loads an entry with random content unless it already holds a code
    task automatic ensure_entry(int tsel, int sym);
        int len;
        int roll;
        if (sb.loaded[tsel * 256 + sym]) return;
        roll = $urandom_range(0, 99);
        if (roll < 5) len = 0;
        else if (roll < 10) len = $urandom_range(17, 31);
        else len = $urandom_range(1, 16);
        load_entry(tsel, sym, $urandom_range(0, 65535), len);
    endtask

    // coefficient transfer; every code it will read is loaded first
    task automatic send_coeff(int comp, int pos, int coeff);
        logic [jee_pkg::TDATA_W-1:0] d;
        int ch, run;
        if (comp != int'(jee_pkg::COMP_NONE)) begin
            ch = (comp != 0);
            if (pos == 0) begin
                ensure_entry(ch, sb.size_of(sb.dc_diff(comp, coeff)));
            end else if (coeff == 0) begin
                if (pos == int'(jee_pkg::LAST_POS))
                    ensure_entry(2 | ch, int'(jee_pkg::SYM_EOB));
            end else begin
                run = sb.zero_run;
                if (run >= 16) ensure_entry(2 | ch, int'(jee_pkg::SYM_ZRL));
                run = run % 16;
                ensure_entry(2 | ch, (run << 4) | (sb.size_of(coeff) & 15));
            end
        end
        d = junk();
        d[42:31] = 12'(coeff);
        d[48:43] = 6'(pos);
        d[50:49] = 2'(comp);
        send(jee_pkg::CMD_COEFF, d);
    endtask

    task automatic send_flush();
        send(jee_pkg::CMD_FLUSH, junk());
    endtask

    function automatic int rand_ac();
        int m;
        if ($urandom_range(0, 9) == 0) m = $urandom_range(1, 2047);
        else m = $urandom_range(1, 15);
        if ($urandom_range(0, 1)) m = -m;
        if ($urandom_range(0, 99) == 0) m = -2048;
        return m;
    endfunction

    // one block, possibly cut short by the next block start
    task automatic send_block();
        int comp, stop, dc;
        comp = $urandom_range(0, 2);
        case ($urandom_range(0, 9))
            0: dc = 2047;
            1: dc = -2048;
            default: dc = $urandom_range(0, 4095) - 2048;
        endcase
        stop = ($urandom_range(0, 99) < 30) ? 63 : $urandom_range(1, 24);
        send_coeff(comp, 0, dc);
        for (int p = 1; p <= stop; p++) begin
            if ($urandom_range(0, 99) < 75) send_coeff(comp, p, 0);
            else send_coeff(comp, p, rand_ac());
        end
    endtask

    initial begin
        int roll;
        sb         = new();
        items      = 0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = jee_pkg::CMD_LOAD;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: table extremes, stuffing, ignored items, dc extremes, eob, flush
        load_entry(0, 0, 16'hFFFF, 16);             // all-ones code forces stuffing
        load_entry(1, 0, 16'h0000, 0);              // zero-length code
        load_entry(2, int'(jee_pkg::SYM_EOB), 16'hFFFF, 31); // overlong length saturates
        load_entry(3, int'(jee_pkg::SYM_EOB), 16'hA5A5, 3);  // code masked to its length
        send_flush();                               // flush with nothing pending
        send_coeff(0, 0, 0);                        // diff zero: ff ff with stuffing
        send_coeff(1, 0, 0);                        // emits no bits
        send_coeff(0, 0, 2047);
        send_coeff(0, 0, -2048);                    // largest dc difference
        send_coeff(2, 0, -2048);
        send_coeff(0, 1, 2047);
        send_coeff(0, 2, -2048);
        send_coeff(0, 63, 0);                       // end of block
        send_coeff(1, 1, 0);
        send_coeff(1, 63, 0);
        send_coeff(int'(jee_pkg::COMP_NONE), 0, 123); // ignored component
        send(CMD_NONE, junk());                     // ignored command
        send_coeff(0, 0, 5);
        send_coeff(0, 5, 1);
        send_coeff(0, 0, -7);                       // restarted block
        send_flush();                               // pads the partial byte

        // random: mostly well formed blocks with reloads, flushes and noise
        while (items < ITEM_GOAL) begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                send_block();
            end else if (roll < 70) begin
                load_entry($urandom_range(0, 3), $urandom_range(0, 255),
                           $urandom_range(0, 65535), $urandom_range(0, 31));
            end else if (roll < 78) begin
                send_flush();
            end else if (roll < 86) begin
                if ($urandom_range(0, 1)) send(CMD_NONE, junk());
                else send_coeff(int'(jee_pkg::COMP_NONE), $urandom_range(0, 63), rand_ac());
            end else if (roll < 92) begin
                // out-of-order positions: saturating zero run, then a value
                roll = $urandom_range(0, 2);
                send_coeff(roll, 0, $urandom_range(0, 255));
                repeat ($urandom_range(10, 70)) send_coeff(roll, $urandom_range(1, 62), 0);
                send_coeff(roll, $urandom_range(1, 63), rand_ac());
            end else begin
                send_coeff($urandom_range(0, 2), $urandom_range(1, 63),
                           ($urandom_range(0, 1)) ? 0 : rand_ac());
            end
        end
        send_flush();

        while (sb.scan_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.scan_q.size() == 0) begin
            $display("jpeg_entropy_encoder_tb: PASS");
        end else begin
            $display("jpeg_entropy_encoder_tb: FAIL");
        end
        $finish;
    end
endmodule
